/* rtl/gfl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package gfl_pkg;

  // Default sizes of the block
  localparam int unsigned NumOrderParamsDef = 6;
  localparam int unsigned MaxGrainsDef      = 256;
  localparam int unsigned DimensionsDef     = 3;

  // Field widths
  localparam int unsigned CoordW  = 16;
  localparam int unsigned LabelW  = 16;
  localparam int unsigned ParamW  = 3;
  localparam int unsigned RadiusW = 16;
  localparam int unsigned CenterW = 3 * CoordW;
  localparam int unsigned EntryW  = LabelW + ParamW + RadiusW + CenterW;
  // Squared distance over up to three dimensions
  localparam int unsigned D2W     = 34;
  localparam int unsigned CfgDataW = 16;

  // Reset value of the sum threshold (0.01 in Q2.13)
  localparam logic [14:0] SumThresholdRst = 15'd82;
  // -1.0 in Q2.13
  localparam logic signed [15:0] MinusOneQ13 = -16'sd8192;

  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_POINT = 1'b1
  } gfl_op_e;

  typedef enum logic [1:0] {
    CFG_HALF_BUFFER   = 2'd0,
    CFG_GRAIN_COUNT   = 2'd1,
    CFG_SUM_THRESHOLD = 2'd2
  } gfl_cfg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } gfl_state_e;

  // One table entry travelling down the distance chain
  typedef struct packed {
    logic               valid;
    logic               last;
    logic [LabelW-1:0]  label;
    logic [ParamW-1:0]  param;
    logic [RadiusW-1:0] radius;
    logic [CenterW-1:0] center;
    logic [D2W-1:0]     acc;
  } gfl_cell_t;

endpackage

`default_nettype wire

/* rtl/gfl_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface gfl_in_if;
  logic        valid;
  logic        ready;
  logic [0:0]  operation;
  logic [7:0]  entry_index;
  logic [15:0] grain_label;
  logic [2:0]  grain_param_index;
  logic [15:0] grain_radius;
  logic signed [15:0] coord_x;
  logic signed [15:0] coord_y;
  logic signed [15:0] coord_z;
  logic [47:0] params_low;
  logic [47:0] params_high;

  modport source (
    output valid, operation, entry_index, grain_label, grain_param_index,
           grain_radius, coord_x, coord_y, coord_z, params_low, params_high,
    input  ready
  );
  modport sink (
    input  valid, operation, entry_index, grain_label, grain_param_index,
           grain_radius, coord_x, coord_y, coord_z, params_low, params_high,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/gfl_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface gfl_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] feature_id;
  logic signed [3:0]  dominant_param;

  modport source (
    output valid, feature_id, dominant_param,
    input  ready
  );
  modport sink (
    input  valid, feature_id, dominant_param,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/gfl_cfg_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface gfl_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reg_index;
  logic [15:0] wdata;

  modport source (
    output valid, reg_index, wdata,
    input  ready
  );
  modport sink (
    input  valid, reg_index, wdata,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/gfl_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module gfl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write one word, read one word with registered data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/gfl_dist_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module gfl_dist_cell #(
  parameter int unsigned CellIdx = 0
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [15:0]            point_coord_i,
  input  wire gfl_pkg::gfl_cell_t     cell_i,
  output gfl_pkg::gfl_cell_t          cell_o
);
  import gfl_pkg::*;

  gfl_cell_t          a_q, b_q;
  logic signed [16:0] diff_d, diff_q;
  logic signed [33:0] prod;
  logic [31:0]        sq_q;

  // Difference of this cell's coordinate
  assign diff_d = 17'($signed(point_coord_i)) -
                  17'($signed(cell_i.center[CellIdx*CoordW +: CoordW]));
  assign prod   = 34'(diff_q) * 34'(diff_q);

  // Advance entry and valid flag, square, then accumulate on the way out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q    <= '0;
      b_q    <= '0;
      diff_q <= '0;
      sq_q   <= '0;
    end else begin
      a_q    <= cell_i;
      diff_q <= diff_d;
      b_q    <= a_q;
      sq_q   <= prod[31:0];
    end
  end

  always_comb begin
    cell_o     = b_q;
    cell_o.acc = b_q.acc + D2W'(sq_q);
  end

endmodule

`default_nettype wire

/* rtl/grain_feature_labeler.sv */
`timescale 1ns / 1ps
`default_nettype none
// Table write request: accepted only while idle, no result; writes can follow every cycle while idle.
// Point request: entries 0 to n-1 are read from the table, where n = min(grain_count, MAX_GRAINS),
// and pass the distance chain, the reach compare and the match register before the result is
// registered; when n is zero or no parameter exceeds -1.0, the scan is skipped. One point is in
// flight at a time: the next request is taken after the result is loaded, later while an earlier
// result waits; the scan makes one RAM read per table entry. Reset clears control and loads the
// register defaults; table contents are undefined until written, and no clearing pass runs.

module grain_feature_labeler #(
  parameter int unsigned NUM_ORDER_PARAMS = gfl_pkg::NumOrderParamsDef,
  parameter int unsigned MAX_GRAINS       = gfl_pkg::MaxGrainsDef,
  parameter int unsigned DIMENSIONS       = gfl_pkg::DimensionsDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  gfl_cfg_if.sink   cfg_i,
  gfl_in_if.sink    in_i,
  gfl_out_if.source out_o
);
  import gfl_pkg::*;

  localparam int unsigned AddrW = (MAX_GRAINS > 1) ? $clog2(MAX_GRAINS) : 1;
  localparam int unsigned CntW  = $clog2(MAX_GRAINS + 1);
  localparam int unsigned SumW  = 16 + $clog2(NUM_ORDER_PARAMS);

  // Configuration registers
  logic [15:0] half_buffer_q;
  logic [8:0]  grain_count_q;
  logic [14:0] sum_thr_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_buffer_q <= '0;
      grain_count_q <= '0;
      sum_thr_q     <= SumThresholdRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.reg_index)
        CFG_HALF_BUFFER:   half_buffer_q <= cfg_i.wdata;
        CFG_GRAIN_COUNT:   grain_count_q <= cfg_i.wdata[8:0];
        CFG_SUM_THRESHOLD: sum_thr_q     <= cfg_i.wdata[14:0];
        default: ;
      endcase
    end
  end

  // Control
  gfl_state_e state_q, state_d;
  logic       in_fire, is_point, tbl_we, rd_en, rd_last, load_out;
  logic       out_valid_q;
  logic       f1_valid_q, f1_last_q;

  assign in_fire  = in_i.valid && in_i.ready;
  assign is_point = (in_i.operation == OP_POINT);

  // Dominant order parameter and sum
  logic [16*NUM_ORDER_PARAMS-1:0] params_all;
  logic signed [15:0]             best_val, lane_v;
  logic [2:0]                     best_idx_d;
  logic                           best_ok_d;
  logic signed [SumW-1:0]         sum_d;
  logic                           sum_ok_d;

  assign params_all = (16*NUM_ORDER_PARAMS)'({in_i.params_high, in_i.params_low});

  always_comb begin
    best_val   = MinusOneQ13;
    best_idx_d = '0;
    best_ok_d  = 1'b0;
    sum_d      = '0;
    lane_v     = '0;
    for (int i = 0; i < NUM_ORDER_PARAMS; i++) begin
      lane_v = $signed(params_all[16*i +: 16]);
      sum_d  = sum_d + SumW'(lane_v);
      if (lane_v > best_val) begin
        best_val   = lane_v;
        best_idx_d = 3'(i);
        best_ok_d  = 1'b1;
      end
    end
    sum_ok_d = !($signed(sum_d) < $signed(SumW'({1'b0, sum_thr_q})));
  end

  // Entry count of the scan
  logic [CntW-1:0] n_d, n_q, rd_addr_q;

  assign n_d = (32'(grain_count_q) > 32'(MAX_GRAINS)) ? CntW'(MAX_GRAINS)
                                                      : CntW'(grain_count_q);
  assign rd_last = (rd_addr_q == n_q - CntW'(1));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && is_point) begin
          state_d = (n_d == '0 || !best_ok_d) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (f1_valid_q && f1_last_q) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_i.ready = (state_q == ST_IDLE);
    rd_en      = (state_q == ST_SCAN);
    load_out   = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);
  end

  assign tbl_we = in_fire && !is_point && (32'(in_i.entry_index) < 32'(MAX_GRAINS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rd_addr_q <= '0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        rd_addr_q <= '0;
      end else if (rd_en) begin
        rd_addr_q <= rd_addr_q + CntW'(1);
      end
    end
  end

  // Point request context
  logic [DIMENSIONS-1:0][15:0] pt_q;
  logic [2:0]                  best_idx_q;
  logic                        best_ok_q, sum_ok_q;
  logic [47:0]                 coord_all;

  assign coord_all = {in_i.coord_z, in_i.coord_y, in_i.coord_x};

  always_ff @(posedge clk_i) begin
    if (in_fire && is_point) begin
      pt_q       <= coord_all[16*DIMENSIONS-1:0];
      best_idx_q <= best_idx_d;
      best_ok_q  <= best_ok_d;
      sum_ok_q   <= sum_ok_d;
      n_q        <= n_d;
    end
  end

  // Grain table
  logic [EntryW-1:0] wdata, rdata;
  logic [31:0]       widx;
  logic [31:0]       ridx;

  assign wdata = {in_i.coord_z, in_i.coord_y, in_i.coord_x, in_i.grain_radius,
                  in_i.grain_param_index, in_i.grain_label};
  assign widx  = 32'(in_i.entry_index);
  assign ridx  = 32'(rd_addr_q);

  gfl_ram #(
    .Width(EntryW),
    .Depth(MAX_GRAINS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (tbl_we),
    .waddr_i(widx[AddrW-1:0]),
    .wdata_i(wdata),
    .re_i   (rd_en),
    .raddr_i(ridx[AddrW-1:0]),
    .rdata_o(rdata)
  );

  // Align read flags with RAM data
  logic rv_q, rl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= 1'b0;
      rl_q <= 1'b0;
    end else begin
      rv_q <= rd_en;
      rl_q <= rd_en && rd_last;
    end
  end

  // Distance chain: one cell per dimension
  gfl_cell_t chain [DIMENSIONS+1];

  always_comb begin
    chain[0].valid  = rv_q;
    chain[0].last   = rl_q;
    chain[0].label  = rdata[LabelW-1:0];
    chain[0].param  = rdata[LabelW +: ParamW];
    chain[0].radius = rdata[LabelW+ParamW +: RadiusW];
    chain[0].center = rdata[LabelW+ParamW+RadiusW +: CenterW];
    chain[0].acc    = '0;
  end

  for (genvar d = 0; d < DIMENSIONS; d++) begin : g_cell
    gfl_dist_cell #(
      .CellIdx(d)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .point_coord_i(pt_q[d]),
      .cell_i       (chain[d]),
      .cell_o       (chain[d+1])
    );
  end

  // Reach squared and parameter match
  gfl_cell_t          tail;
  logic [16:0]        reach;
  logic [33:0]        reach_sq_q;
  logic [D2W-1:0]     d2_q;
  logic [LabelW-1:0]  f1_label_q;
  logic               f1_match_q;

  assign tail  = chain[DIMENSIONS];
  assign reach = {1'b0, tail.radius} + {1'b0, half_buffer_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
      f1_last_q  <= 1'b0;
    end else begin
      f1_valid_q <= tail.valid;
      f1_last_q  <= tail.valid && tail.last;
    end
  end

  always_ff @(posedge clk_i) begin
    reach_sq_q <= 34'(reach) * 34'(reach);
    d2_q       <= tail.acc;
    f1_label_q <= tail.label;
    f1_match_q <= (tail.param == best_idx_q);
  end

  // Keep the last matching grain of the scan
  logic              found_q;
  logic [LabelW-1:0] found_label_q;

  always_ff @(posedge clk_i) begin
    if (in_fire && is_point) begin
      found_q <= 1'b0;
    end else if (f1_valid_q && f1_match_q && (D2W'(d2_q) < D2W'(reach_sq_q))) begin
      found_q       <= 1'b1;
      found_label_q <= f1_label_q;
    end
  end

  // Result register
  logic signed [16:0] feature_q;
  logic signed [3:0]  dominant_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      if (!sum_ok_q || !best_ok_q) begin
        feature_q  <= -17'sd1;
        dominant_q <= -4'sd1;
      end else begin
        feature_q  <= found_q ? $signed({1'b0, found_label_q}) : -17'sd1;
        dominant_q <= $signed({1'b0, best_idx_q});
      end
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.feature_id     = feature_q;
  assign out_o.dominant_param = dominant_q;

endmodule

`default_nettype wire
